// File: rtl/core/tcrr_pkg.sv
package tcrr_pkg;

	typedef struct packed {
		logic       command;
		logic [3:0] code;
	} cmd_t;

	typedef struct packed {
		logic [2:0] action;
		logic [1:0] mode;
		logic       overflow;
		logic       last;
	} res_t;

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_REC  = 2'd1;
	localparam logic [1:0] MODE_PLAY = 2'd2;

	localparam logic [3:0] CODE_LIGHTS = 4'd6;
	localparam logic [3:0] CODE_REC    = 4'd7;
	localparam logic [3:0] CODE_ENDREC = 4'd8;
	localparam logic [3:0] CODE_PLAY   = 4'd9;
	localparam logic [3:0] CODE_ABORT  = 4'd10;
	localparam logic [3:0] CODE_MOTION_MAX = 4'd5;

	localparam logic [2:0] ACT_NONE   = 3'd0;
	localparam logic [2:0] ACT_LIGHTS = 3'd7;

	localparam int MAX_RESULTS = 64;
	localparam int NUM_W = $clog2(MAX_RESULTS + 1);

	function automatic logic [2:0] drive_action(input logic [3:0] code, input logic lights_ok);
		logic [2:0] a;
		a = ACT_NONE;
		if (code <= CODE_MOTION_MAX) begin
			a = code[2:0] + 3'd1;
		end else if (code == CODE_LIGHTS && lights_ok) begin
			a = ACT_LIGHTS;
		end
		return a;
	endfunction

endpackage

// File: rtl/core/timed_command_record_replay.sv
// Timed command record and replay sequencer.
// Input channel cmd (cmd_valid, cmd_stall): one item is a drive command event
// (command 0, code) or a one millisecond tick (command 1).
// Result channel res (res_valid, res_stall): drive action, mode after the
// result, overflow flag and last, which marks the final result of an item.
// An ordinary item is taken in ST_IN; then ST_EXEC updates the mode, timer
// and store and loads the output register, once that register is free.
// A replay tick reads the store one entry at a time over its single read
// port, through ST_RD and ST_CMP for each entry examined, then ends in
// ST_FIN; a tick releases at most 64 entries.
// The item channel stalls while an item is in progress; one item at a time.
// When the receiver stalls, the finished result waits in the output register
// and the block holds until it is taken.
// Reset puts the block in idle with an empty store and a zero timer; the
// store itself is not cleared, entries are read only after being written.
module timed_command_record_replay
	import tcrr_pkg::*;
#(
	parameter int STORE_DEPTH = 256,
	parameter int TIME_BITS   = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CW = $clog2(STORE_DEPTH + 1);
	localparam int EW = TIME_BITS + 4;
	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
	localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);
	localparam logic [NUM_W-1:0] MAX_C = NUM_W'(MAX_RESULTS);

	typedef enum logic [4:0] {
		ST_IN   = 5'b00001,
		ST_EXEC = 5'b00010,
		ST_RD   = 5'b00100,
		ST_CMP  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t state_q;
	logic [1:0] mode_q;
	logic [TIME_BITS-1:0] elapsed_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] ridx_q;
	logic [NUM_W-1:0] num_q;
	cmd_t item_q;
	logic pend_v_q;
	logic [2:0] pend_act_q;
	logic [1:0] pend_mode_q;
	logic res_valid_q;
	res_t res_q;

	logic [EW-1:0] mem [STORE_DEPTH];
	logic [EW-1:0] rdata_s1;
	logic wr_en;
	logic rd_en;

	logic out_free;
	logic [TIME_BITS-1:0] elapsed_inc;
	logic [TIME_BITS-1:0] rd_stamp;
	logic [3:0] rd_code;
	logic [CW-1:0] ridx_nxt;

	assign out_free    = !res_valid_q || !res_stall;
	assign elapsed_inc = (elapsed_q == TIME_MAX) ? elapsed_q : elapsed_q + 1'b1;
	assign rd_stamp    = rdata_s1[EW-1:4];
	assign rd_code     = rdata_s1[3:0];
	assign ridx_nxt    = ridx_q + 1'b1;

	assign cmd_stall = (state_q != ST_IN);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign wr_en = (state_q == ST_EXEC) && out_free && (mode_q == MODE_REC)
		&& !item_q.command && (item_q.code != CODE_ENDREC) && (count_q < DEPTH_C);
	assign rd_en = (state_q == ST_RD) && (num_q < MAX_C) && (ridx_q < count_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[AW-1:0]] <= {elapsed_q, item_q.code};
		end
		if (rd_en) begin
			rdata_s1 <= mem[ridx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IN && cmd_valid) begin
			item_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IN;
			mode_q      <= MODE_IDLE;
			elapsed_q   <= '0;
			count_q     <= '0;
			ridx_q      <= '0;
			num_q       <= '0;
			pend_v_q    <= 1'b0;
			pend_act_q  <= ACT_NONE;
			pend_mode_q <= MODE_IDLE;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IN: begin
					if (cmd_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (mode_q == MODE_PLAY && item_q.command) begin
						elapsed_q <= elapsed_inc;
						num_q     <= '0;
						state_q   <= ST_RD;
					end else if (out_free) begin
						res_valid_q    <= 1'b1;
						res_q.action   <= ACT_NONE;
						res_q.overflow <= 1'b0;
						res_q.last     <= 1'b1;
						res_q.mode     <= mode_q;
						state_q        <= ST_IN;
						case (mode_q)
							MODE_IDLE: begin
								if (!item_q.command) begin
									if (item_q.code == CODE_REC) begin
										mode_q     <= MODE_REC;
										res_q.mode <= MODE_REC;
										count_q    <= '0;
										elapsed_q  <= '0;
									end else if (item_q.code == CODE_PLAY) begin
										if (count_q != '0) begin
											mode_q     <= MODE_PLAY;
											res_q.mode <= MODE_PLAY;
											ridx_q     <= '0;
											elapsed_q  <= '0;
										end
									end else begin
										res_q.action <= drive_action(item_q.code, 1'b0);
									end
								end
							end
							MODE_REC: begin
								if (item_q.command) begin
									elapsed_q <= elapsed_inc;
								end else if (item_q.code == CODE_ENDREC) begin
									mode_q     <= MODE_IDLE;
									res_q.mode <= MODE_IDLE;
								end else begin
									res_q.action <= drive_action(item_q.code, 1'b0);
									if (count_q < DEPTH_C) begin
										count_q <= count_q + 1'b1;
									end else begin
										res_q.overflow <= 1'b1;
									end
								end
							end
							MODE_PLAY: begin
								if (item_q.code == CODE_ABORT) begin
									mode_q     <= MODE_IDLE;
									res_q.mode <= MODE_IDLE;
								end
							end
							default: begin
								mode_q     <= MODE_IDLE;
								res_q.mode <= MODE_IDLE;
							end
						endcase
					end
				end
				ST_RD: begin
					state_q <= rd_en ? ST_CMP : ST_FIN;
				end
				ST_CMP: begin
					if (rd_stamp > elapsed_q) begin
						state_q <= ST_FIN;
					end else if (!pend_v_q || out_free) begin
						if (pend_v_q) begin
							res_valid_q    <= 1'b1;
							res_q.action   <= pend_act_q;
							res_q.mode     <= pend_mode_q;
							res_q.overflow <= 1'b0;
							res_q.last     <= 1'b0;
						end
						pend_v_q   <= 1'b1;
						pend_act_q <= drive_action(rd_code, 1'b1);
						ridx_q     <= ridx_nxt;
						num_q      <= num_q + 1'b1;
						if (ridx_nxt >= count_q) begin
							mode_q      <= MODE_IDLE;
							pend_mode_q <= MODE_IDLE;
						end else begin
							pend_mode_q <= mode_q;
						end
						state_q <= ST_RD;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						res_valid_q    <= 1'b1;
						res_q.action   <= pend_v_q ? pend_act_q : ACT_NONE;
						res_q.mode     <= pend_v_q ? pend_mode_q : mode_q;
						res_q.overflow <= 1'b0;
						res_q.last     <= 1'b1;
						pend_v_q       <= 1'b0;
						state_q        <= ST_IN;
					end
				end
				default: begin
					state_q <= ST_IN;
				end
			endcase
		end
	end

endmodule
